FILE: rtl/affine_transform_composer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the transform composer.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_COMPOSER_DEFINES_SVH
`define AFFINE_TRANSFORM_COMPOSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// Transform composer package
// Fixed-point constants, operation codes, item types and trigonometric tables.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 66;
	localparam int TBL_N     = 91;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	localparam logic [3:0] F_WRITE  = 4'd0;
	localparam logic [3:0] F_IDENT  = 4'd1;
	localparam logic [3:0] F_TRANS  = 4'd2;
	localparam logic [3:0] F_ROTX   = 4'd3;
	localparam logic [3:0] F_ROTY   = 4'd4;
	localparam logic [3:0] F_ROTZ   = 4'd5;
	localparam logic [3:0] F_SCALE  = 4'd6;
	localparam logic [3:0] F_SCALAR = 4'd7;
	localparam logic [3:0] F_POINT  = 4'd8;
	localparam logic [3:0] F_READ   = 4'd9;

	typedef struct packed {
		logic [3:0]        func;
		logic [3:0]        elem_index;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] z_in;
		logic [8:0]        angle_deg;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic              saturated;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic first;
	} mac_ctl_t;

	function automatic longint q30_to_frac(input longint v);
		return (v + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	endfunction

	function automatic logic [TBL_N*32-1:0] trig_tbl(input bit want_cos);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		longint ss;
		longint cc;
		longint bs;
		longint bc;
		int rr;
		logic [TBL_N*32-1:0] tbl;
		tbl = '0;
		for (int r = 0; r < TBL_N; r++) begin
			rr = (r > 45) ? 90 - r : r;
			x  = (64'(rr) * PI_Q30 + 64'd90) / 64'd180;
			x2 = (x * x) >> 30;
			t  = x;
			ss = longint'(x);
			cc = longint'(1) <<< 30;
			for (int k = 1; k <= 6; k++) begin
				t  = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				ss = (k % 2 == 1) ? ss - longint'(t) : ss + longint'(t);
			end
			t = 64'd1 << 30;
			for (int k = 1; k <= 7; k++) begin
				t  = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
				cc = (k % 2 == 1) ? cc - longint'(t) : cc + longint'(t);
			end
			if (ss < 0) ss = 0;
			if (ss > (longint'(1) <<< 30)) ss = longint'(1) <<< 30;
			if (cc < 0) cc = 0;
			if (cc > (longint'(1) <<< 30)) cc = longint'(1) <<< 30;
			bs = (r > 45) ? q30_to_frac(cc) : q30_to_frac(ss);
			bc = (r > 45) ? q30_to_frac(ss) : q30_to_frac(cc);
			tbl[r*32 +: 32] = want_cos ? 32'(bc) : 32'(bs);
		end
		return tbl;
	endfunction

	localparam logic [TBL_N*32-1:0] SIN_TBL = trig_tbl(1'b0);
	localparam logic [TBL_N*32-1:0] COS_TBL = trig_tbl(1'b1);

endpackage

`default_nettype wire

FILE: rtl/affine_transform_composer.sv
// ----------------------------------------------------------------------------
// Affine transform composer
// Holds a 4x4 Q16.16 matrix and applies one operation per item through a
// single shared multiply-accumulate unit.
//
// Channel  Signals                    Direction
// req      req_valid, req_stall, req  item in
// rsp      rsp_valid, rsp_stall, rsp  item out
//
// A new item is taken only while idle, so each item completes before the next
// is accepted. Write, identity, read and unused codes go straight to the result.
// Rotations first wait for angle reduction. Translate, scale and rotations form
// each element as a four-product sum, scalar multiply uses a single product per
// element and point transform sums four products per coordinate, all through the one multiplier.
// Reset loads the identity; a stalled result holds the next item at the end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_transform_composer_defines.svh"

module affine_transform_composer (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  atc_pkg::req_t      req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output atc_pkg::rsp_t      rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TRIG  = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_STORE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [3:0] func_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [1:0] row_q, col_q, k_q;
	logic       sat_q;
	logic signed [31:0] mat_q [16];
	logic signed [31:0] rowbuf_q [3];

	logic        acc;
	logic        is_rot;
	logic        is_mul;
	logic [1:0]  last_k;
	logic [3:0]  rd_addr;
	logic signed [31:0] rd_data;
	logic signed [31:0] opb;
	logic        trig_done;
	logic signed [31:0] sin_v, cos_v;
	atc_pkg::mac_ctl_t mac_ctl;
	logic signed [31:0] mac_res;
	logic        mac_sat;
	logic        out_load;

	function automatic logic signed [31:0] b_elem(
		input logic [3:0] f,
		input logic [1:0] k,
		input logic [1:0] c,
		input logic signed [31:0] x,
		input logic signed [31:0] y,
		input logic signed [31:0] z,
		input logic signed [31:0] s,
		input logic signed [31:0] co
	);
		logic signed [31:0] v;
		v = (k == c) ? atc_pkg::ONE : 32'sd0;
		case (f)
			atc_pkg::F_TRANS: begin
				if (c == 2'd3 && k == 2'd0) v = x;
				if (c == 2'd3 && k == 2'd1) v = y;
				if (c == 2'd3 && k == 2'd2) v = z;
			end
			atc_pkg::F_ROTX: begin
				if (k == 2'd1 && c == 2'd1) v = co;
				if (k == 2'd1 && c == 2'd2) v = -s;
				if (k == 2'd2 && c == 2'd1) v = s;
				if (k == 2'd2 && c == 2'd2) v = co;
			end
			atc_pkg::F_ROTY: begin
				if (k == 2'd0 && c == 2'd0) v = co;
				if (k == 2'd0 && c == 2'd2) v = s;
				if (k == 2'd2 && c == 2'd0) v = -s;
				if (k == 2'd2 && c == 2'd2) v = co;
			end
			atc_pkg::F_ROTZ: begin
				if (k == 2'd0 && c == 2'd0) v = co;
				if (k == 2'd0 && c == 2'd1) v = -s;
				if (k == 2'd1 && c == 2'd0) v = s;
				if (k == 2'd1 && c == 2'd1) v = co;
			end
			atc_pkg::F_SCALE: begin
				if (k == 2'd0 && c == 2'd0) v = x;
				if (k == 2'd1 && c == 2'd1) v = y;
				if (k == 2'd2 && c == 2'd2) v = z;
			end
			default: ;
		endcase
		return v;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign is_rot    = (req.func == atc_pkg::F_ROTX) || (req.func == atc_pkg::F_ROTY) ||
	                   (req.func == atc_pkg::F_ROTZ);
	assign is_mul    = (req.func == atc_pkg::F_TRANS) || (req.func == atc_pkg::F_SCALE) ||
	                   (req.func == atc_pkg::F_SCALAR) || (req.func == atc_pkg::F_POINT);
	assign last_k    = (func_q == atc_pkg::F_SCALAR) ? 2'd0 : 2'd3;
	assign out_load  = (state_q == S_FIN) && (!rsp_valid || !rsp_stall);

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = req.elem_index;
		end else if (func_q == atc_pkg::F_SCALAR) begin
			rd_addr = {row_q, col_q};
		end else begin
			rd_addr = {row_q, k_q};
		end
		rd_data = mat_q[rd_addr];
		case (func_q)
			atc_pkg::F_SCALAR: opb = x_q;
			atc_pkg::F_POINT: begin
				case (k_q)
					2'd0: opb = x_q;
					2'd1: opb = y_q;
					2'd2: opb = z_q;
					default: opb = atc_pkg::ONE;
				endcase
			end
			default: opb = b_elem(func_q, k_q, col_q, x_q, y_q, z_q, sin_v, cos_v);
		endcase
		mac_ctl.en    = (state_q == S_ISSUE);
		mac_ctl.first = (k_q == 2'd0);
	end

	atc_trig u_trig (
		.clk   (clk),
		.arst_n(arst_n),
		.start (acc && is_rot),
		.angle (req.angle_deg),
		.done  (trig_done),
		.sin_v (sin_v),
		.cos_v (cos_v)
	);

	atc_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.a     (rd_data),
		.b     (opb),
		.res   (mac_res),
		.sat   (mac_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? atc_pkg::ONE : 32'sd0;
			end
		end else begin
			if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
			if (out_load) rsp_valid <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.func == atc_pkg::F_WRITE) begin
							mat_q[req.elem_index] <= req.x_in;
						end
						if (req.func == atc_pkg::F_IDENT) begin
							for (int i = 0; i < 16; i++) begin
								mat_q[i] <= (i % 5 == 0) ? atc_pkg::ONE : 32'sd0;
							end
						end
						if (is_rot) state_q <= S_TRIG;
						else if (is_mul) state_q <= S_ISSUE;
						else state_q <= S_FIN;
					end
				end
				S_TRIG: begin
					if (trig_done) state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (k_q == last_k) state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_STORE;
				S_STORE: begin
					state_q <= S_ISSUE;
					if (func_q == atc_pkg::F_SCALAR) begin
						mat_q[{row_q, col_q}] <= mac_res;
						if (row_q == 2'd3 && col_q == 2'd3) state_q <= S_FIN;
					end else if (func_q == atc_pkg::F_POINT) begin
						if (row_q == 2'd2) state_q <= S_FIN;
					end else if (col_q == 2'd3) begin
						mat_q[{row_q, 2'd0}] <= rowbuf_q[0];
						mat_q[{row_q, 2'd1}] <= rowbuf_q[1];
						mat_q[{row_q, 2'd2}] <= rowbuf_q[2];
						mat_q[{row_q, 2'd3}] <= mac_res;
						if (row_q == 2'd3) state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				x_q    <= req.x_in;
				y_q    <= req.y_in;
				z_q    <= req.z_in;
				row_q  <= 2'd0;
				col_q  <= 2'd0;
				k_q    <= 2'd0;
				sat_q  <= 1'b0;
				ox_q   <= (req.func == atc_pkg::F_READ) ? rd_data : 32'sd0;
				oy_q   <= 32'sd0;
				oz_q   <= 32'sd0;
			end
			S_ISSUE: begin
				if (k_q != last_k) k_q <= k_q + 2'd1;
			end
			S_STORE: begin
				k_q   <= 2'd0;
				sat_q <= sat_q | mac_sat;
				if (func_q == atc_pkg::F_SCALAR) begin
					{row_q, col_q} <= {row_q, col_q} + 4'd1;
				end else if (func_q == atc_pkg::F_POINT) begin
					case (row_q)
						2'd0: ox_q <= mac_res;
						2'd1: oy_q <= mac_res;
						default: oz_q <= mac_res;
					endcase
					row_q <= row_q + 2'd1;
				end else begin
					if (col_q != 2'd3) rowbuf_q[col_q] <= mac_res;
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) row_q <= row_q + 2'd1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			rsp.out_x     <= ox_q;
			rsp.out_y     <= oy_q;
			rsp.out_z     <= oz_q;
			rsp.saturated <= sat_q;
		end
	end

	`ATC_ASSERT_NOW(a_trig_in_trig, trig_done, state_q == S_TRIG, "rotation table done outside rotation wait")
	`ATC_ASSERT_NOW(a_wait_last_k, state_q == S_WAIT, k_q == last_k, "sum closed before all products issued")
	`ATC_ASSERT_NEXT(a_yz_zero, out_load && func_q != atc_pkg::F_POINT, rsp.out_y == 32'sd0 && rsp.out_z == 32'sd0, "non-point item left y or z non-zero")

endmodule

`default_nettype wire

FILE: rtl/atc_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered 32x32 product, exact accumulation, floor shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_mac (
	input  wire                  clk,
	input  wire                  arst_n,
	input  atc_pkg::mac_ctl_t    ctl,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [31:0]   res,
	output logic                 sat
);

	logic signed [63:0] prod_s1;
	logic               vld_s1;
	logic               first_s1;
	logic signed [atc_pkg::ACC_W-1:0] acc_q;
	logic signed [atc_pkg::ACC_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			vld_s1   <= ctl.en;
			first_s1 <= ctl.first;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1 <= a * b;
		end
		if (vld_s1) begin
			acc_q <= first_s1 ? atc_pkg::ACC_W'(prod_s1) : acc_q + atc_pkg::ACC_W'(prod_s1);
		end
	end

	always_comb begin
		shifted = acc_q >>> atc_pkg::FRAC_BITS;
		if (shifted > atc_pkg::ACC_W'(64'sh7FFF_FFFF)) begin
			res = 32'sh7FFF_FFFF;
			sat = 1'b1;
		end else if (shifted < -atc_pkg::ACC_W'(64'sh8000_0000)) begin
			res = 32'sh8000_0000;
			sat = 1'b1;
		end else begin
			res = shifted[31:0];
			sat = 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/atc_trig.sv
// ----------------------------------------------------------------------------
// Angle reduction and sine/cosine lookup
// Reduces the angle by repeated subtraction, then reads the quarter tables.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_trig (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire logic [8:0]      angle,
	output logic                 done,
	output logic signed [31:0]   sin_v,
	output logic signed [31:0]   cos_v
);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_MOD  = 2'd1;
	localparam logic [1:0] T_QUAD = 2'd2;
	localparam logic [1:0] T_LOOK = 2'd3;

	logic [1:0]  st_q;
	logic [8:0]  a_q;
	logic [1:0]  q_q;
	logic [11:0] base;
	logic signed [31:0] bs;
	logic signed [31:0] bc;

	assign base = {a_q[6:0], 5'd0};
	assign bs   = atc_pkg::SIN_TBL[base +: 32];
	assign bc   = atc_pkg::COS_TBL[base +: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (start) st_q <= T_MOD;
				end
				T_MOD: st_q <= T_QUAD;
				T_QUAD: begin
					if (a_q < 9'd90) st_q <= T_LOOK;
				end
				T_LOOK: begin
					st_q <= T_IDLE;
					done <= 1'b1;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			T_IDLE: begin
				a_q <= angle;
				q_q <= 2'd0;
			end
			T_MOD: begin
				if (a_q >= 9'd360) a_q <= a_q - 9'd360;
			end
			T_QUAD: begin
				if (a_q >= 9'd90) begin
					a_q <= a_q - 9'd90;
					q_q <= q_q + 2'd1;
				end
			end
			T_LOOK: begin
				case (q_q)
					2'd0: begin sin_v <= bs;  cos_v <= bc;  end
					2'd1: begin sin_v <= bc;  cos_v <= -bs; end
					2'd2: begin sin_v <= -bs; cos_v <= -bc; end
					default: begin sin_v <= -bc; cos_v <= bs; end
				endcase
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
